/* design/imlu_pkg.sv */
// Shared types and constants for the Ising lattice update core.
// Used by imlu_ctrl, imlu_datapath and ising_metropolis_lattice_update_core.
package imlu_pkg;

  localparam int LATTICE_SIDE = 64;
  localparam int SITE_COUNT   = LATTICE_SIDE * LATTICE_SIDE;
  localparam int SIDE_W       = $clog2(LATTICE_SIDE);
  localparam int COORD_W      = (SIDE_W > 6) ? SIDE_W : 6;
  localparam int ADDR_W       = $clog2(SITE_COUNT);

  localparam int SKIP_W = 7;
  localparam int THR_W  = 12;
  localparam int TBL_W  = 60;
  localparam int DRAW_W = 7;
  localparam int MAG_W  = 14;

  localparam logic [THR_W-1:0]  ALWAYS_FLIP = 12'd4095;
  localparam logic [SKIP_W-1:0] SKIP_RESET  = 7'd80;

  localparam logic [1:0] CFG_SKIP     = 2'd0;
  localparam logic [1:0] CFG_THR_UP   = 2'd1;
  localparam logic [1:0] CFG_THR_DOWN = 2'd2;

  // lattice word: bit 1 flip mark, bit 0 spin (1 = -1)
  localparam int SPIN_BIT = 0;
  localparam int MARK_BIT = 1;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_EVAL   = 2'd1,
    REQ_COMMIT = 2'd2,
    REQ_READ   = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    RD_SITE = 2'd0,
    RD_NBR  = 2'd1,
    RD_WALK = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    load_req;
    logic    walk_clear;
    logic    walk_step;
    logic    wr_clear;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    nbr_clear;
    logic    nbr_step;
    logic    capture_site;
    logic    load_write;
    logic    decide;
    logic    out_load;
  } imlu_cmd_t;

  typedef struct packed {
    logic req_commit;
    logic load_go;
    logic eval_go;
    logic walk_last;
    logic nbr_last;
    logic out_free;
  } imlu_stat_t;

  function automatic addr_t site_addr(coord_t r, coord_t c);
    return ADDR_W'(int'(r) * LATTICE_SIDE + int'(c));
  endfunction

endpackage

/* design/imlu_ctrl.sv */
// Sequencer for the Ising lattice update core: clear pass, sweep, request steps.
// Depends on imlu_pkg.
module imlu_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  imlu_pkg::imlu_stat_t stat,
  output imlu_pkg::imlu_cmd_t  cmd
);
  import imlu_pkg::*;

  typedef enum logic [10:0] {
    ST_CLEAR     = 11'b00000000001,
    ST_IDLE      = 11'b00000000010,
    ST_SWEEP     = 11'b00000000100,
    ST_SWEEP_END = 11'b00000001000,
    ST_FETCH     = 11'b00000010000,
    ST_SITE      = 11'b00000100000,
    ST_LOAD_WR   = 11'b00001000000,
    ST_NBR       = 11'b00010000000,
    ST_NBR_END   = 11'b00100000000,
    ST_DECIDE    = 11'b01000000000,
    ST_DONE      = 11'b10000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_SITE;
    unique case (state)
      ST_CLEAR: begin
        cmd.wr_clear = 1'b1;
        if (stat.walk_last) begin
          cmd.walk_clear = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = stat.req_commit ? ST_SWEEP : ST_FETCH;
        end
      end
      ST_SWEEP: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_WALK;
        if (stat.walk_last) begin
          cmd.walk_clear = 1'b1;
          state_next     = ST_SWEEP_END;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      ST_SWEEP_END: begin
        state_next = ST_FETCH;
      end
      ST_FETCH: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_SITE;
        state_next = ST_SITE;
      end
      ST_SITE: begin
        cmd.capture_site = 1'b1;
        cmd.nbr_clear    = 1'b1;
        if (stat.load_go) begin
          state_next = ST_LOAD_WR;
        end else if (stat.eval_go) begin
          state_next = ST_NBR;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_LOAD_WR: begin
        cmd.load_write = 1'b1;
        state_next     = ST_DONE;
      end
      ST_NBR: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_NBR;
        cmd.nbr_step = 1'b1;
        if (stat.nbr_last) begin
          state_next = ST_NBR_END;
        end
      end
      ST_NBR_END: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

/* design/imlu_datapath.sv */
// Datapath of the Ising lattice update core: lattice memory, config registers,
// neighbor count, threshold compare, magnetization and result register. Uses imlu_pkg.
module imlu_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [1:0]                 req_type,
  input  logic [5:0]                 row,
  input  logic [5:0]                 column,
  input  logic                       spin_in,
  input  logic [imlu_pkg::DRAW_W-1:0] site_draw,
  input  logic [imlu_pkg::THR_W-1:0]  accept_draw,
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic                       spin_out,
  output logic                       flip_marked,
  output logic signed [imlu_pkg::MAG_W-1:0] magnetization,
  input  logic                       cfg_write_en,
  input  logic [1:0]                 cfg_index,
  input  logic [imlu_pkg::TBL_W-1:0]  cfg_data,
  input  imlu_pkg::imlu_cmd_t         cmd,
  output imlu_pkg::imlu_stat_t        stat
);
  import imlu_pkg::*;

  logic [1:0] lattice_mem [SITE_COUNT];

  logic [SKIP_W-1:0] skip_cutoff;
  logic [TBL_W-1:0]  thr_up;
  logic [TBL_W-1:0]  thr_down;

  req_kind_t         kind_q;
  coord_t            row_q;
  coord_t            col_q;
  logic              spin_q;
  logic [DRAW_W-1:0] sdraw_q;
  logic [THR_W-1:0]  adraw_q;

  addr_t      walk_cnt;
  addr_t      walk_addr_q;
  logic       walk_rd_v;
  logic       nbr_rd_v;
  logic [1:0] nbr_cnt;
  logic [2:0] neg_cnt;
  logic [1:0] rd_data;
  logic [1:0] site_word;
  logic signed [MAG_W-1:0] mag;

  logic       addr_ok;
  addr_t      site_a;
  addr_t      nbr_a;
  addr_t      rd_addr;
  coord_t     nbr_r;
  coord_t     nbr_c;
  logic       we;
  addr_t      wa;
  logic [1:0] wd;
  logic [2:0] thr_k;
  logic [TBL_W-1:0] tbl;
  logic [THR_W-1:0] thr;
  logic       mark_new;

  assign addr_ok = (int'(row_q) < LATTICE_SIDE) && (int'(col_q) < LATTICE_SIDE);
  assign site_a  = site_addr(row_q, col_q);

  always_comb begin
    nbr_r = row_q;
    nbr_c = col_q;
    case (nbr_cnt)
      2'd0: nbr_r = (row_q == '0) ? COORD_W'(LATTICE_SIDE - 1) : row_q - 1'b1;
      2'd1: nbr_r = (row_q == COORD_W'(LATTICE_SIDE - 1)) ? '0 : row_q + 1'b1;
      2'd2: nbr_c = (col_q == '0) ? COORD_W'(LATTICE_SIDE - 1) : col_q - 1'b1;
      default: nbr_c = (col_q == COORD_W'(LATTICE_SIDE - 1)) ? '0 : col_q + 1'b1;
    endcase
  end
  assign nbr_a = site_addr(nbr_r, nbr_c);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_NBR:  rd_addr = nbr_a;
      RD_WALK: rd_addr = walk_cnt;
      default: rd_addr = site_a;
    endcase
  end

  // threshold index: +1 site uses 4 - neg, -1 site uses neg
  assign thr_k = site_word[SPIN_BIT] ? neg_cnt : 3'd4 - neg_cnt;
  assign tbl   = site_word[SPIN_BIT] ? thr_down : thr_up;
  always_comb begin
    case (thr_k)
      3'd0:    thr = tbl[11:0];
      3'd1:    thr = tbl[23:12];
      3'd2:    thr = tbl[35:24];
      3'd3:    thr = tbl[47:36];
      3'd4:    thr = tbl[59:48];
      default: thr = '0;
    endcase
  end
  assign mark_new = (thr == ALWAYS_FLIP) || (adraw_q < thr);

  always_comb begin
    we = 1'b0;
    wa = site_a;
    wd = '0;
    if (cmd.wr_clear) begin
      we = 1'b1;
      wa = walk_cnt;
    end else if (cmd.load_write) begin
      we = 1'b1;
      wd = {site_word[MARK_BIT], spin_q};
    end else if (cmd.decide) begin
      we = mark_new;
      wd = {1'b1, site_word[SPIN_BIT]};
    end else if (walk_rd_v) begin
      we = rd_data[MARK_BIT];
      wa = walk_addr_q;
      wd = {1'b0, ~rd_data[SPIN_BIT]};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      lattice_mem[wa] <= wd;
    end
    if (cmd.rd_en) begin
      rd_data <= lattice_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_cutoff <= SKIP_RESET;
      thr_up      <= '0;
      thr_down    <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_SKIP:     skip_cutoff <= cfg_data[SKIP_W-1:0];
        CFG_THR_UP:   thr_up      <= cfg_data;
        CFG_THR_DOWN: thr_down    <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind_q  <= req_kind_t'(req_type);
      row_q   <= COORD_W'(row);
      col_q   <= COORD_W'(column);
      spin_q  <= spin_in;
      sdraw_q <= site_draw;
      adraw_q <= accept_draw;
    end
    if (cmd.rd_en && cmd.rd_sel == RD_WALK) begin
      walk_addr_q <= walk_cnt;
    end
    if (cmd.capture_site) begin
      site_word <= rd_data;
    end else if (cmd.load_write) begin
      site_word <= {site_word[MARK_BIT], spin_q};
    end else if (cmd.decide) begin
      site_word <= {site_word[MARK_BIT] | mark_new, site_word[SPIN_BIT]};
    end
    if (cmd.nbr_clear) begin
      neg_cnt <= '0;
    end else if (nbr_rd_v && rd_data[SPIN_BIT]) begin
      neg_cnt <= neg_cnt + 3'd1;
    end
    if (cmd.out_load) begin
      spin_out      <= addr_ok & site_word[SPIN_BIT];
      flip_marked   <= addr_ok & site_word[MARK_BIT];
      magnetization <= mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_cnt  <= '0;
      walk_rd_v <= 1'b0;
      nbr_rd_v  <= 1'b0;
      nbr_cnt   <= '0;
      res_valid <= 1'b0;
      mag       <= MAG_W'(SITE_COUNT);
    end else begin
      walk_rd_v <= cmd.rd_en && (cmd.rd_sel == RD_WALK);
      nbr_rd_v  <= cmd.rd_en && (cmd.rd_sel == RD_NBR);
      if (cmd.walk_clear) begin
        walk_cnt <= '0;
      end else if (cmd.walk_step) begin
        walk_cnt <= walk_cnt + 1'b1;
      end
      if (cmd.nbr_clear) begin
        nbr_cnt <= '0;
      end else if (cmd.nbr_step) begin
        nbr_cnt <= nbr_cnt + 2'd1;
      end
      if (cmd.out_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (cmd.load_write && (site_word[SPIN_BIT] != spin_q)) begin
        mag <= spin_q ? mag - MAG_W'(2) : mag + MAG_W'(2);
      end else if (walk_rd_v && rd_data[MARK_BIT]) begin
        mag <= rd_data[SPIN_BIT] ? mag + MAG_W'(2) : mag - MAG_W'(2);
      end
    end
  end

  assign stat.req_commit = (req_kind_t'(req_type) == REQ_COMMIT);
  assign stat.load_go    = addr_ok && (kind_q == REQ_LOAD);
  assign stat.eval_go    = addr_ok && (kind_q == REQ_EVAL) && (sdraw_q >= skip_cutoff);
  assign stat.walk_last  = (walk_cnt == ADDR_W'(SITE_COUNT - 1));
  assign stat.nbr_last   = (nbr_cnt == 2'd3);
  assign stat.out_free   = !res_valid || !res_stall;

endmodule

/* design/ising_metropolis_lattice_update_core.sv */
// Top level of the Ising Metropolis lattice update core.
// Joins imlu_ctrl and imlu_datapath; types and constants from imlu_pkg.
//
//   channel  | handshake            | payload
//   request  | req_valid, req_stall | req_type, row, column, spin_in, site_draw, accept_draw
//   result   | res_valid, res_stall | spin_out, flip_marked, magnetization
//   config   | cfg_write_en         | cfg_index, cfg_data
//
// One request at a time; every lattice read goes through the single read port.
// Per request: site read; load adds a write; evaluate adds neighbor reads unless skipped.
// After reset a clearing pass over all SITE_COUNT (4096) sites holds req_stall high.
// A request is taken while the previous result still waits in the result register.
module ising_metropolis_lattice_update_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [1:0]                  req_type,
  input  logic [5:0]                  row,
  input  logic [5:0]                  column,
  input  logic                        spin_in,
  input  logic [imlu_pkg::DRAW_W-1:0] site_draw,
  input  logic [imlu_pkg::THR_W-1:0]  accept_draw,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic                        spin_out,
  output logic                        flip_marked,
  output logic signed [imlu_pkg::MAG_W-1:0] magnetization,
  input  logic                        cfg_write_en,
  input  logic [1:0]                  cfg_index,
  input  logic [imlu_pkg::TBL_W-1:0]  cfg_data
);
  import imlu_pkg::*;

  imlu_cmd_t  cmd;
  imlu_stat_t stat;

  imlu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  imlu_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .req_type      (req_type),
    .row           (row),
    .column        (column),
    .spin_in       (spin_in),
    .site_draw     (site_draw),
    .accept_draw   (accept_draw),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .spin_out      (spin_out),
    .flip_marked   (flip_marked),
    .magnetization (magnetization),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule
